// File: rtl/tslh_pkg.sv
package tslh_pkg;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration port shape
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // input word
   typedef struct packed {
      logic               command;
      logic [11:0]        pixel_index;
      logic [6:0]         class_index;
      logic signed [15:0] score;
      logic               last_class;
   } req_type;

   // result word
   typedef struct packed {
      logic [11:0] out_pixel_index;
      logic [1:0]  label;
      logic        held;
      logic [6:0]  winning_class;
   } rsp_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [16:0] smoothing_weight;
      logic [14:0] hysteresis_margin;
   } cfg_type;

   // classified word held in the queue
   typedef struct packed {
      logic               command;
      logic               class_ok;
      logic [11:0]        pixel_index;
      logic [6:0]         class_index;
      logic signed [15:0] score;
      logic               last_class;
   } entry_type;

   // smoothed score on its way to the ranking stage
   typedef struct packed {
      logic               command;
      logic               ranked;
      logic               last_class;
      logic               hist;
      logic [11:0]        pixel_index;
      logic [6:0]         class_index;
      logic signed [15:0] value;
   } rank_type;

   // finished pixel on its way to the hysteresis stage
   typedef struct packed {
      logic        hist;
      logic [11:0] pixel_index;
      logic [6:0]  best_class;
      logic [15:0] spread;
   } decide_type;

endpackage

// File: rtl/tslh_front.sv
module tslh_front
   import tslh_pkg::*;
#(
   parameter int PIXELS = 4096,
   parameter int CLASSES = 65,
   localparam int ADDR_W = $clog2(PIXELS * CLASSES)
) (
   input  req_type             req_data,
   output entry_type           entry,
   output logic [ADDR_W-1:0]   entry_addr,
   output logic                keep
);

   logic pixel_ok;

   // range checks on pixel and class
   always_comb begin
      pixel_ok          = 32'(req_data.pixel_index) < 32'(PIXELS);
      entry.command     = req_data.command;
      entry.class_ok    = 32'(req_data.class_index) < 32'(CLASSES);
      entry.pixel_index = req_data.pixel_index;
      entry.class_index = req_data.class_index;
      entry.score       = req_data.score;
      entry.last_class  = req_data.last_class;
      // out-of-range pixels are dropped here
      keep              = req_data.command | pixel_ok;
   end

   // score memory address, pixel-major
   assign entry_addr = ADDR_W'(req_data.pixel_index) * ADDR_W'(CLASSES)
                     + ADDR_W'(req_data.class_index);

endmodule

// File: rtl/tslh_queue.sv
module tslh_queue
   import tslh_pkg::*;
#(
   parameter int PIXELS = 4096,
   parameter int CLASSES = 65,
   localparam int ADDR_W = $clog2(PIXELS * CLASSES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic [ADDR_W-1:0] push_addr,
   input  logic              pop,
   output entry_type         head_entry,
   output logic [ADDR_W-1:0] head_addr,
   output logic              empty,
   output logic              full
);

   entry_type               entry_ff [QUEUE_DEPTH];
   logic [ADDR_W-1:0]       addr_ff  [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign empty      = count_ff == '0;
   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
         addr_ff[wr_ptr_ff]  <= push_addr;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue written while full");
   no_underflow: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("queue read while empty");

endmodule

// File: rtl/tslh_back.sv
module tslh_back
   import tslh_pkg::*;
#(
   parameter int PIXELS = 4096,
   parameter int CLASSES = 65,
   localparam int ADDR_W = $clog2(PIXELS * CLASSES),
   localparam int PIX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1,
   localparam int DEPTH = PIXELS * CLASSES
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  entry_type         head_entry,
   input  logic [ADDR_W-1:0] head_addr,
   input  logic              q_empty,
   output logic              pop,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              rsp_stall
);

   localparam logic [1:0]         LABEL_NONE     = 2'd0;
   localparam logic [1:0]         LABEL_ROAD     = 2'd1;
   localparam logic [1:0]         LABEL_SIDEWALK = 2'd2;
   localparam logic [15:0]        SIGN_FLIP      = 16'h8000;
   localparam logic signed [34:0] ROUND_HALF     = 35'sd32768;
   localparam logic signed [15:0] SCORE_FLOOR    = -16'sd32768;

   function automatic logic [1:0] class_label(input logic [6:0] c);
      logic [1:0] l;
      case (c) inside
         7'd7, 7'd8, 7'd10, 7'd13, 7'd14, 7'd23, 7'd24: l = LABEL_ROAD;
         7'd9, 7'd11, 7'd15:                            l = LABEL_SIDEWALK;
         default:                                       l = LABEL_NONE;
      endcase
      return l;
   endfunction

   // memories
   logic [15:0] score_mem [DEPTH];
   logic        valid_mem [PIXELS];
   logic [1:0]  label_mem [PIXELS];

   logic en;

   // history clear sweep
   logic             sweep_busy_ff, sweep_busy_in;
   logic [PIX_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic             sweep_last;

   // stage 1: memory read data and blend
   logic              s1_valid_ff;
   entry_type         s1_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [15:0]       score_rd_ff;
   logic              hist_rd_ff;
   logic              score_wr, valid_wr;
   logic              hist;
   logic [15:0]       old_score;
   logic [15:0]       pu, su, nu, stored;
   logic signed [16:0] delta;
   logic signed [17:0] weight_s;
   logic signed [34:0] product, rounded;
   logic signed [18:0] incr, blended;
   rank_type          rank_in;

   // one-step write forwarding
   logic              sfw_valid_ff;
   logic [ADDR_W-1:0] sfw_addr_ff;
   logic [15:0]       sfw_data_ff;
   logic              vfw_valid_ff;
   logic [11:0]       vfw_pix_ff;
   logic              lfw_valid_ff;
   logic [11:0]       lfw_pix_ff;
   logic [1:0]        lfw_label_ff;

   // stage 2: ranking
   logic               s2_valid_ff;
   rank_type           s2_ff;
   logic signed [15:0] best_ff, best_in;
   logic signed [15:0] second_ff, second_in;
   logic [6:0]         bclass_ff, bclass_in;
   logic signed [15:0] b, s;
   logic [6:0]         c;
   logic signed [16:0] spread_wide;
   decide_type         decide_in;
   logic               s3_load;

   // stage 3: hysteresis
   logic        s3_valid_ff;
   decide_type  s3_ff;
   logic [1:0]  label_rd_ff;
   logic [1:0]  base_label, prev_label, final_label;
   logic        hold;
   rsp_type     rsp_in;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // the back pipeline moves whenever the output register can take a word
   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && !q_empty && !sweep_busy_ff && !(s1_valid_ff && s1_ff.command);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sweep control: after reset and after a clear command
   always_comb begin
      sweep_last = sweep_cnt_ff == PIX_W'(PIXELS - 1);
      if (sweep_busy_ff) begin
         sweep_busy_in = !sweep_last;
         sweep_cnt_in  = sweep_last ? '0 : sweep_cnt_ff + 1'b1;
      end else begin
         sweep_busy_in = en && s1_valid_ff && s1_ff.command;
         sweep_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_busy_ff <= 1'b1;
         sweep_cnt_ff  <= '0;
      end else begin
         sweep_busy_ff <= sweep_busy_in;
         sweep_cnt_ff  <= sweep_cnt_in;
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff      <= head_entry;
         s1_addr_ff <= head_addr;
      end
   end

   // score memory, read at pop, written from stage 1
   always_ff @(posedge clock) begin
      if (pop) begin
         score_rd_ff <= score_mem[head_addr];
      end
      if (en && score_wr) begin
         score_mem[s1_addr_ff] <= stored;
      end
   end

   // history valid memory, swept clear or set by a finished pixel
   always_ff @(posedge clock) begin
      if (pop) begin
         hist_rd_ff <= valid_mem[PIX_W'(head_entry.pixel_index)];
      end
      if (sweep_busy_ff) begin
         valid_mem[sweep_cnt_ff] <= 1'b0;
      end else if (en && valid_wr) begin
         valid_mem[PIX_W'(s1_ff.pixel_index)] <= 1'b1;
      end
   end

   // stage 1 blend: old + round(w * (new - old)) with history, else the new score
   always_comb begin
      score_wr  = s1_valid_ff && !s1_ff.command && s1_ff.class_ok;
      valid_wr  = s1_valid_ff && !s1_ff.command && s1_ff.last_class;
      hist      = hist_rd_ff || (vfw_valid_ff && vfw_pix_ff == s1_ff.pixel_index);
      old_score = (sfw_valid_ff && sfw_addr_ff == s1_addr_ff) ? sfw_data_ff : score_rd_ff;
      pu        = old_score ^ SIGN_FLIP;
      su        = s1_ff.score ^ SIGN_FLIP;
      delta     = $signed({1'b0, su}) - $signed({1'b0, pu});
      weight_s  = $signed({1'b0, cfg.smoothing_weight});
      product   = weight_s * delta;
      rounded   = product + ROUND_HALF;
      incr      = rounded[34:16];
      blended   = $signed({3'b000, pu}) + incr;
      if (!hist) begin
         nu = su;
      end else if (blended[18]) begin
         nu = '0;
      end else if (blended[17:16] != 2'b00) begin
         nu = '1;
      end else begin
         nu = blended[15:0];
      end
      stored = nu ^ SIGN_FLIP;

      rank_in.command     = s1_ff.command;
      rank_in.ranked      = !s1_ff.command && s1_ff.class_ok;
      rank_in.last_class  = s1_ff.last_class;
      rank_in.hist        = hist;
      rank_in.pixel_index = s1_ff.pixel_index;
      rank_in.class_index = s1_ff.class_index;
      rank_in.value       = $signed(stored);
   end

   // forwarding registers, each covers the write of the previous step
   always_ff @(posedge clock) begin
      if (reset) begin
         sfw_valid_ff <= 1'b0;
         vfw_valid_ff <= 1'b0;
         lfw_valid_ff <= 1'b0;
      end else if (en) begin
         sfw_valid_ff <= score_wr;
         vfw_valid_ff <= valid_wr;
         lfw_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sfw_addr_ff  <= s1_addr_ff;
         sfw_data_ff  <= stored;
         vfw_pix_ff   <= s1_ff.pixel_index;
         lfw_pix_ff   <= s3_ff.pixel_index;
         lfw_label_ff <= final_label;
      end
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= rank_in;
      end
   end

   // best and second-best tracking, earlier class wins a tie
   always_comb begin
      b = best_ff;
      s = second_ff;
      c = bclass_ff;
      if (s2_ff.ranked) begin
         if (s2_ff.value > best_ff) begin
            s = best_ff;
            b = s2_ff.value;
            c = s2_ff.class_index;
         end else if (s2_ff.value > second_ff) begin
            s = s2_ff.value;
         end
      end
      spread_wide = 17'(b) - 17'(s);

      decide_in.hist        = s2_ff.hist;
      decide_in.pixel_index = s2_ff.pixel_index;
      decide_in.best_class  = c;
      decide_in.spread      = spread_wide[15:0];

      s3_load = s2_valid_ff && !s2_ff.command && s2_ff.last_class;

      best_in   = best_ff;
      second_in = second_ff;
      bclass_in = bclass_ff;
      if (s2_valid_ff) begin
         if (s2_ff.command || s2_ff.last_class) begin
            best_in   = SCORE_FLOOR;
            second_in = SCORE_FLOOR;
            bclass_in = '0;
         end else begin
            best_in   = b;
            second_in = s;
            bclass_in = c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= SCORE_FLOOR;
         second_ff <= SCORE_FLOOR;
         bclass_ff <= '0;
      end else if (en) begin
         best_ff   <= best_in;
         second_ff <= second_in;
         bclass_ff <= bclass_in;
      end
   end

   // stage 3 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s3_load;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= decide_in;
      end
   end

   // previous label memory, read in stage 2, written from stage 3
   always_ff @(posedge clock) begin
      if (en && s3_load) begin
         label_rd_ff <= label_mem[PIX_W'(s2_ff.pixel_index)];
      end
      if (en && s3_valid_ff) begin
         label_mem[PIX_W'(s3_ff.pixel_index)] <= final_label;
      end
   end

   // hysteresis on the label change
   always_comb begin
      base_label = class_label(s3_ff.best_class);
      prev_label = (lfw_valid_ff && lfw_pix_ff == s3_ff.pixel_index) ? lfw_label_ff
                                                                     : label_rd_ff;
      hold = s3_ff.hist && (base_label != prev_label)
           && ({1'b0, s3_ff.spread} < {2'b00, cfg.hysteresis_margin});
      final_label = hold ? prev_label : base_label;

      rsp_in.out_pixel_index = s3_ff.pixel_index;
      rsp_in.label           = final_label;
      rsp_in.held            = hold;
      rsp_in.winning_class   = s3_ff.best_class;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy_ff |-> !pop)
      else $error("word taken from queue during history sweep");
   tracker_order: assert property (@(posedge clock) disable iff (reset)
      best_ff >= second_ff)
      else $error("second-best score above best score");
   clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      en && s1_valid_ff && s1_ff.command |=> sweep_busy_ff && !s1_valid_ff)
      else $error("clear command did not start a history sweep");

endmodule

// File: rtl/temporal_surface_label_hysteresis_core.sv
// path: a last-class word goes through the queue, memory read, blend, ranking and hysteresis
//   to rsp; throughput: one word per cycle while rsp is not stalled and no sweep or clear
//   command holds the pop, set by the score memory read-modify-write in the blend stage
// reset and clear command: a history sweep of all PIXELS pixels (4096 at default) clears the
//   per-pixel valid bits; words wait in the 4-entry queue and req_stall rises when it fills
// configuration resets to weight 32768 and margin 0 and is taken at any time
module temporal_surface_label_hysteresis_core
   import tslh_pkg::*;
#(
   parameter int PIXELS = 4096,
   parameter int CLASSES = 65
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(PIXELS * CLASSES);

   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_WEIGHT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS_MARGIN = 2'd1;
   localparam logic [16:0]            WEIGHT_FULL           = 17'd65536;
   localparam logic [16:0]            WEIGHT_RESET          = 17'd32768;

   cfg_type           cfg_ff, cfg_in;
   entry_type         front_entry, head_entry;
   logic [ADDR_W-1:0] front_addr, head_addr;
   logic              keep, push, pop, q_empty, q_full;

   // configuration registers, weight saturates at full scale
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SMOOTHING_WEIGHT: begin
               cfg_in.smoothing_weight = (csr_data > WEIGHT_FULL) ? WEIGHT_FULL : csr_data;
            end
            CSR_HYSTERESIS_MARGIN: begin
               cfg_in.hysteresis_margin = csr_data[14:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_weight  <= WEIGHT_RESET;
         cfg_ff.hysteresis_margin <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify and drop out-of-range pixels
   tslh_front #(
      .PIXELS  (PIXELS),
      .CLASSES (CLASSES)
   ) u_front (
      .req_data   (req_data),
      .entry      (front_entry),
      .entry_addr (front_addr),
      .keep       (keep)
   );

   assign req_stall = q_full;
   assign push      = req_valid && !q_full && keep;

   tslh_queue #(
      .PIXELS  (PIXELS),
      .CLASSES (CLASSES)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .push_addr  (front_addr),
      .pop        (pop),
      .head_entry (head_entry),
      .head_addr  (head_addr),
      .empty      (q_empty),
      .full       (q_full)
   );

   // back: blend, rank, hysteresis
   tslh_back #(
      .PIXELS  (PIXELS),
      .CLASSES (CLASSES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_entry (head_entry),
      .head_addr  (head_addr),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

// File: bench/temporal_surface_label_hysteresis_core_tb.sv
module temporal_surface_label_hysteresis_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tslh_pkg::*;

   localparam int PIXELS  = 4096;
   localparam int CLASSES = 65;
   localparam int PERIOD  = 10;

   // history sweep after reset or a clear, plus pipeline slack
   localparam int SWEEP_WAIT = PIXELS + 64;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   localparam bit CMD_SCORE = 1'b0;
   localparam bit CMD_CLEAR = 1'b1;

   localparam bit [1:0] LABEL_NONE     = 2'd0;
   localparam bit [1:0] LABEL_ROAD     = 2'd1;
   localparam bit [1:0] LABEL_SIDEWALK = 2'd2;

   localparam int unsigned REG_WEIGHT = 0;
   localparam int unsigned REG_MARGIN = 1;
   localparam int unsigned REG_UNUSED = 2;

   // per-pixel label tracker and store of labels still to come
   class label_scoreboard;
      bit [15:0] smoothed [PIXELS*CLASSES];
      bit        filled [PIXELS*CLASSES];
      bit        has_history [PIXELS];
      bit [1:0]  last_label [PIXELS];
      int        best_val;
      int        second_val;
      bit [6:0]  best_cls;
      bit [16:0] weight;
      bit [14:0] margin;
      rsp_type   pending_labels [$];
      int        errors;

      function new();
         foreach (has_history[i]) has_history[i] = 1'b0;
         restart_ranking();
         weight = 17'd32768;
         margin = 15'd0;
         errors = 0;
      endfunction

      function void restart_ranking();
         best_val = -32768;
         second_val = -32768;
         best_cls = 7'd0;
      endfunction

      function bit [1:0] surface_of(bit [6:0] c);
         case (c)
            7, 8, 10, 13, 14, 23, 24: return LABEL_ROAD;
            9, 11, 15: return LABEL_SIDEWALK;
            default: return LABEL_NONE;
         endcase
      endfunction

      // true when a score word for this pixel and class reads nothing unwritten
      function bit can_read(int pix, int cls);
         return cls >= CLASSES || !has_history[pix] || filled[pix*CLASSES+cls];
      endfunction

      function void write_reg(int unsigned idx, bit [16:0] value);
         case (idx)
            REG_WEIGHT: weight = value;
            REG_MARGIN: margin = value[14:0];
            default: ;
         endcase
      endfunction

      // blend, rank and on the last class decide the label of one accepted word
      function void absorb_word(req_type w);
         bit                 had;
         int                 pix;
         int                 addr;
         int                 v;
         bit [15:0]          raw_ob;
         longint unsigned    wt;
         longint unsigned    su;
         longint unsigned    nu;
         longint unsigned    acc;
         bit [1:0]           lab;
         bit                 kept;
         rsp_type            r;
         if (w.command == CMD_CLEAR) begin
            foreach (has_history[i]) has_history[i] = 1'b0;
            restart_ranking();
            return;
         end
         pix = w.pixel_index;
         had = has_history[pix];
         wt = (weight > 17'd65536) ? 65536 : weight;
         if (w.class_index < CLASSES) begin
            addr = pix * CLASSES + w.class_index;
            raw_ob = w.score ^ 16'h8000;
            su = raw_ob;
            nu = su;
            if (had) begin
               acc = wt * su + (65536 - wt) * smoothed[addr] + 32768;
               nu = acc >> 16;
               if (nu > 65535) nu = 65535;
            end
            smoothed[addr] = nu[15:0];
            filled[addr] = 1'b1;
            v = int'(nu) - 32768;
            if (v > best_val) begin
               second_val = best_val;
               best_val = v;
               best_cls = w.class_index;
            end else if (v > second_val) begin
               second_val = v;
            end
         end
         if (!w.last_class) return;
         lab = surface_of(best_cls);
         kept = 1'b0;
         // hysteresis only against an existing label
         if (had && lab != last_label[pix] && (best_val - second_val) < int'(margin)) begin
            lab = last_label[pix];
            kept = 1'b1;
         end
         last_label[pix] = lab;
         has_history[pix] = 1'b1;
         r.out_pixel_index = w.pixel_index;
         r.label = lab;
         r.held = kept;
         r.winning_class = best_cls;
         pending_labels = {pending_labels, r};
         restart_ranking();
      endfunction

      function void check_label(rsp_type got);
         rsp_type exp;
         if (pending_labels.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, got);
            errors++;
            return;
         end
         exp = pending_labels.pop_front();
         if (got.out_pixel_index !== exp.out_pixel_index) begin
            $display("%0t: pixel mismatch, expected %0d, got %0d", $time,
                     exp.out_pixel_index, got.out_pixel_index);
            errors++;
         end
         if (got.label !== exp.label) begin
            $display("%0t: label mismatch on pixel %0d, expected %0d, got %0d", $time,
                     exp.out_pixel_index, exp.label, got.label);
            errors++;
         end
         if (got.held !== exp.held) begin
            $display("%0t: held mismatch on pixel %0d, expected %0d, got %0d", $time,
                     exp.out_pixel_index, exp.held, got.held);
            errors++;
         end
         if (got.winning_class !== exp.winning_class) begin
            $display("%0t: winning class mismatch on pixel %0d, expected %0d, got %0d",
                     $time, exp.out_pixel_index, exp.winning_class, got.winning_class);
            errors++;
         end
      endfunction

      function int pending();
         return pending_labels.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   label_scoreboard sb;
   int              burst_left;
   int              items_sent;
   bit [11:0]       pool [8];

   temporal_surface_label_hysteresis_core #(
      .PIXELS(PIXELS),
      .CLASSES(CLASSES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(PERIOD/2) clock = ~clock;

   // drop valid at the next falling edge, then hold off for some cycles
   task automatic sender_idle(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // one input word, with burst gaps in front of it
   task automatic send_word(req_type w);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) sender_idle($urandom_range(1, 10));
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.absorb_word(w);
      items_sent++;
   endtask

   function automatic req_type make_word(bit cmd, int pix, int cls, logic [15:0] s, bit last);
      req_type w;
      w.command = cmd;
      w.pixel_index = 12'(pix);
      w.class_index = 7'(cls);
      w.score = s;
      w.last_class = last;
      return w;
   endfunction

   task automatic write_csr(int unsigned idx, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_W'(idx);
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, CSR_DATA_W'(value));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_labels();
      sender_idle(0);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // registers change only with nothing in flight, a history sweep included
   task automatic settle_and_configure(int unsigned wt, int unsigned mg);
      wait_for_labels();
      sender_idle(SWEEP_WAIT);
      write_csr(REG_WEIGHT, wt);
      write_csr(REG_MARGIN, mg);
   endtask

   function automatic int pick_pixel();
      if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 7)];
      return $urandom_range(0, PIXELS - 1);
   endfunction

   // swap a class that would read an unwritten score for an out-of-range one
   function automatic int safe_class(int pix, int cls);
      if (sb.can_read(pix, cls)) return cls;
      return CLASSES + $urandom_range(0, 127 - CLASSES);
   endfunction

   // one pixel, ascending classes, in one mode a favored class standing out
   task automatic send_pixel(int pix);
      int          favs [12] = '{7, 8, 9, 10, 11, 13, 14, 15, 23, 24, 0, 64};
      int          picks [$];
      int          fav;
      int          n;
      int          mode;
      int          base;
      logic [15:0] s;
      if ($urandom_range(0, 4) == 0) begin
         fav = -1;
         n = $urandom_range(1, 6);
      end else begin
         fav = ($urandom_range(0, 19) == 0) ? 64 : favs[$urandom_range(0, 10)];
         n = fav + 1 + $urandom_range(0, 4);
         if (n > CLASSES) n = CLASSES;
      end
      mode = $urandom_range(0, 2);
      base = int'($urandom_range(0, 65531)) - 32768;
      for (int k = 0; k < n; k++) begin
         if (sb.can_read(pix, k)) picks = {picks, k};
      end
      if (picks.size() == 0) picks = {picks, CLASSES + int'($urandom_range(0, 127 - CLASSES))};
      foreach (picks[i]) begin
         case (mode)
            0: s = 16'($urandom);
            1: s = (picks[i] == fav) ? 16'($urandom_range(16384, 32767))
                                     : 16'($urandom_range(0, 32767) - 32768);
            default: s = 16'(base + int'($urandom_range(0, 3)));
         endcase
         send_word(make_word(CMD_SCORE, pix, picks[i], s, i == picks.size() - 1));
      end
   endtask

   // short run of disordered words, pixels switching, last often missing
   task automatic send_broken_run();
      int len;
      int pix;
      int cls;
      bit last;
      len = $urandom_range(1, 6);
      pix = pick_pixel();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0) pix = pick_pixel();
         cls = safe_class(pix, $urandom_range(0, 127));
         last = (i == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
         send_word(make_word(CMD_SCORE, pix, cls, 16'($urandom), last));
      end
   endtask

   task automatic random_step();
      int r;
      int pix;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         send_pixel(pick_pixel());
      end else if (r < 84) begin
         send_broken_run();
      end else if (r < 95) begin
         pix = $urandom_range(0, PIXELS - 1);
         send_word(make_word(CMD_SCORE, pix, safe_class(pix, $urandom_range(0, 127)),
                             16'($urandom), 1'($urandom_range(0, 1))));
      end else if (r < 97) begin
         send_word(make_word(CMD_CLEAR, $urandom_range(0, PIXELS - 1),
                             $urandom_range(0, 127), 16'($urandom), 1'($urandom_range(0, 1))));
      end else if (r < 98) begin
         wait_for_labels();
      end else begin
         sender_idle($urandom_range(20, 60));
      end
   endtask

   // result side: accept at the rising edge, stall pattern changes by stretch
   initial begin : rsp_side
      int mode;
      int left;
      rsp_stall = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_label(rsp_data);
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 300);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (left % 7) < 3;
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("temporal_surface_label_hysteresis_core_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int unsigned wts [5];
      int unsigned mgs [5];
      int          start;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      burst_left = 0;
      items_sent = 0;
      pool[0] = 12'd0;
      pool[1] = 12'd4095;
      for (int i = 2; i < 8; i++) pool[i] = 12'($urandom_range(0, PIXELS - 1));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset weights: extremes of score, ties, classes out of range, pixel change
      send_word(make_word(CMD_SCORE, 0, 0, 16'h8000, 1'b0));
      send_word(make_word(CMD_SCORE, 0, 1, 16'h7fff, 1'b1));
      send_word(make_word(CMD_SCORE, 4095, 7, 16'd100, 1'b1));
      send_word(make_word(CMD_SCORE, 5, 9, 16'd500, 1'b0));
      send_word(make_word(CMD_SCORE, 5, 10, 16'd500, 1'b1));
      send_word(make_word(CMD_SCORE, 6, 127, 16'h7fff, 1'b1));
      send_word(make_word(CMD_SCORE, 7, 11, 16'd1000, 1'b0));
      send_word(make_word(CMD_SCORE, 8, 3, 16'd0, 1'b1));
      // blends with history, rounding right at the half
      send_word(make_word(CMD_SCORE, 4095, 7, 16'h8000, 1'b1));
      send_word(make_word(CMD_SCORE, 0, 0, 16'h7fff, 1'b0));
      send_word(make_word(CMD_SCORE, 0, 1, 16'h8000, 1'b1));
      send_word(make_word(CMD_SCORE, 9, 64, 16'd0, 1'b0));
      send_word(make_word(CMD_SCORE, 9, 65, 16'd0, 1'b1));

      // full weight, widest margin: held labels, then clear drops history
      settle_and_configure(65536, 32767);
      send_word(make_word(CMD_SCORE, 5, 9, 16'd500, 1'b0));
      send_word(make_word(CMD_SCORE, 5, 10, 16'd600, 1'b1));
      send_word(make_word(CMD_SCORE, 8, 100, 16'd0, 1'b1));
      send_word(make_word(CMD_SCORE, 2000, 15, 16'h7fff, 1'b0));
      send_word(make_word(CMD_SCORE, 2000, 24, 16'h7fff, 1'b1));
      send_word(make_word(CMD_CLEAR, 4095, 127, 16'hffff, 1'b1));
      send_word(make_word(CMD_SCORE, 5, 9, 16'd500, 1'b0));
      send_word(make_word(CMD_SCORE, 5, 10, 16'd600, 1'b1));

      // random phases over a spread of settings
      wts = '{131071, 0, 1, 65535, $urandom_range(0, 131071)};
      mgs = '{256, 32767, 4096, 0, $urandom_range(0, 131071)};
      for (int p = 0; p < 5; p++) begin
         settle_and_configure(wts[p], mgs[p]);
         if (p == 0) write_csr(REG_UNUSED, $urandom_range(0, 131071));
         start = items_sent;
         while (items_sent - start < 70) random_step();
      end

      wait_for_labels();
      sender_idle(SWEEP_WAIT);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("temporal_surface_label_hysteresis_core_tb: done, clean");
      end else begin
         $display("temporal_surface_label_hysteresis_core_tb: done, errors");
      end
      $finish;
   end

endmodule
